>>> design/ldg_pkg.sv
// ----------------------------------------------------------------------------
// ldg_pkg
// Shared constants and control types for the decimal digit generator.
// ----------------------------------------------------------------------------
package ldg_pkg;

    // datapath word and counters
    localparam int WORD_W    = 64;
    localparam int BIT_CNT_W = $clog2(WORD_W + 1);
    localparam int DCNT_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int DIGIT_W   = 4;

    // largest number of steps, keeps the result inside 64 bits
    localparam logic [DCNT_W-1:0] DIGIT_MAX = DCNT_W'(19);
    localparam logic [DIGIT_W:0]  DEC_BASE  = (DIGIT_W + 1)'(10);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(3);

    // register reset values
    localparam logic [WORD_W-1:0] MULTIPLIER_RST  = WORD_W'(64'd1664525);
    localparam logic [WORD_W-1:0] INCREMENT_RST   = WORD_W'(64'd1013904223);
    localparam logic [WORD_W-1:0] MODULUS_RST     = WORD_W'(64'd4294967296);
    localparam logic [DCNT_W-1:0] DIGIT_COUNT_RST = DCNT_W'(5);

    // sequencer state codes
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_IDLE   = STATE_W'(0);
    localparam logic [STATE_W-1:0] ST_MUL    = STATE_W'(1);
    localparam logic [STATE_W-1:0] ST_DIV    = STATE_W'(2);
    localparam logic [STATE_W-1:0] ST_DIG    = STATE_W'(3);
    localparam logic [STATE_W-1:0] ST_FINISH = STATE_W'(4);

    // control for the serial arithmetic units
    typedef struct packed {
        logic load;
        logic run;
    } unit_ctl_t;

    // control for the digit unit
    typedef struct packed {
        logic load;
        logic run;
        logic accum;
        logic clear;
    } dig_ctl_t;

endpackage

>>> design/ldg_mul.sv
// ----------------------------------------------------------------------------
// ldg_mul
// Bit-serial multiply-add: product = multiplier * x + increment, mod 2^64.
// ----------------------------------------------------------------------------
module ldg_mul
    import ldg_pkg::*;
(
    input  logic              clk,
    input  unit_ctl_t         ctl,
    input  logic [WORD_W-1:0] multiplier,
    input  logic [WORD_W-1:0] increment,
    input  logic [WORD_W-1:0] x_in,
    output logic [WORD_W-1:0] product
);

    logic [WORD_W-1:0] mcand_reg;
    logic [WORD_W-1:0] mcand_next;
    logic [WORD_W-1:0] mplier_reg;
    logic [WORD_W-1:0] mplier_next;
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;

    // one bit of x_in per cycle, lsb first
    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        sum_next    = sum_reg;
        if (ctl.load)
        begin
            mcand_next  = multiplier;
            mplier_next = x_in;
            sum_next    = increment;
        end
        else if (ctl.run)
        begin
            if (mplier_reg[0])
            begin
                sum_next = sum_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[WORD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[WORD_W-1:1]};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        sum_reg    <= sum_next;
    end

    assign product = sum_reg;

endmodule

>>> design/ldg_div.sv
// ----------------------------------------------------------------------------
// ldg_div
// Restoring remainder unit, one dividend bit per cycle, msb first.
// ----------------------------------------------------------------------------
module ldg_div
    import ldg_pkg::*;
(
    input  logic              clk,
    input  unit_ctl_t         ctl,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] modulus,
    output logic [WORD_W-1:0] remainder
);

    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] quo_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   divisor;

    assign divisor = {1'b0, modulus};
    assign trial   = {rem_reg, quo_reg[WORD_W-1]};

    // shift in next bit, subtract when it fits (zero modulus leaves the sum)
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (ctl.load)
        begin
            quo_next = dividend;
            rem_next = '0;
        end
        else if (ctl.run)
        begin
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            if (trial >= divisor)
            begin
                rem_next = WORD_W'(trial - divisor);
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;

endmodule

>>> design/ldg_dig.sv
// ----------------------------------------------------------------------------
// ldg_dig
// Serial mod-10 of a state word and the decimal accumulator.
// ----------------------------------------------------------------------------
module ldg_dig
    import ldg_pkg::*;
(
    input  logic              clk,
    input  dig_ctl_t          ctl,
    input  logic [WORD_W-1:0] x_in,
    output logic [WORD_W-1:0] acc
);

    logic [WORD_W-1:0]  shift_reg;
    logic [WORD_W-1:0]  shift_next;
    logic [DIGIT_W-1:0] res_reg;
    logic [DIGIT_W-1:0] res_next;
    logic [WORD_W-1:0]  acc_reg;
    logic [WORD_W-1:0]  acc_next;
    logic [DIGIT_W:0]   res_dbl;
    logic [DIGIT_W-1:0] res_step;

    // horner step: r = (2r + bit) mod 10
    assign res_dbl  = {res_reg, shift_reg[WORD_W-1]};
    assign res_step = (res_dbl >= DEC_BASE) ? DIGIT_W'(res_dbl - DEC_BASE)
                                            : res_dbl[DIGIT_W-1:0];

    always_comb
    begin
        shift_next = shift_reg;
        res_next   = res_reg;
        acc_next   = acc_reg;
        if (ctl.load)
        begin
            shift_next = x_in;
            res_next   = '0;
        end
        else if (ctl.run)
        begin
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            res_next   = res_step;
        end
        // acc * 10 + digit, digit taken from the last horner step
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.accum)
        begin
            acc_next = {acc_reg[WORD_W-4:0], 3'b000} + {acc_reg[WORD_W-2:0], 1'b0}
                       + {{(WORD_W-DIGIT_W){1'b0}}, res_step};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        res_reg   <= res_next;
        acc_reg   <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> design/lcg_decimal_digit_generator.sv
// ----------------------------------------------------------------------------
// lcg_decimal_digit_generator
// LCG run for a configured number of steps, collecting the last decimal
// digit of each state into one decimal number.
// ----------------------------------------------------------------------------
// work: n = min(count,19) LCG steps per seed, none when the count is zero;
// one seed is worked on at a time
// each step is a serial multiply-add and a restoring remainder; the
// mod-10 of each state overlaps the next multiply
// reset: registers return to their listed values, no result is pending
// ----------------------------------------------------------------------------
module lcg_decimal_digit_generator
    import ldg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // seed channel
    input  logic                 seed_valid,
    output logic                 seed_stall,
    input  logic [WORD_W-1:0]    seed_value,
    // result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [WORD_W-1:0]    digit_number,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0]    multiplier_reg;
    logic [WORD_W-1:0]    increment_reg;
    logic [WORD_W-1:0]    modulus_reg;
    logic [DCNT_W-1:0]    digit_count_reg;
    logic [STATE_W-1:0]   state_reg;
    logic [STATE_W-1:0]   state_next;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0] cnt_next;
    logic [DCNT_W-1:0]    steps_reg;
    logic [DCNT_W-1:0]    steps_next;
    logic                 have_digit_reg;
    logic                 have_digit_next;
    logic [WORD_W-1:0]    seed_reg;
    logic [WORD_W-1:0]    result_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic                 seed_take;
    logic                 out_free;
    logic                 cnt_last;
    logic [DCNT_W-1:0]    steps_sat;
    logic [WORD_W-1:0]    state_x;
    logic [WORD_W-1:0]    product;
    logic [WORD_W-1:0]    remainder;
    logic [WORD_W-1:0]    acc;
    unit_ctl_t            mul_ctl;
    unit_ctl_t            div_ctl;
    dig_ctl_t             dig_ctl;

    assign cfg_ready  = 1'b1;
    assign seed_stall = (state_reg != ST_IDLE);
    assign seed_take  = seed_valid && !seed_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign cnt_last   = (cnt_reg == BIT_CNT_W'(WORD_W));
    assign steps_sat  = (digit_count_reg > DIGIT_MAX) ? DIGIT_MAX : digit_count_reg;
    // first step starts from the seed, later ones from the last remainder
    assign state_x    = have_digit_reg ? remainder : seed_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg  <= MULTIPLIER_RST;
            increment_reg   <= INCREMENT_RST;
            modulus_reg     <= MODULUS_RST;
            digit_count_reg <= DIGIT_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MULTIPLIER:  multiplier_reg  <= cfg_data;
                REG_INCREMENT:   increment_reg   <= cfg_data;
                REG_MODULUS:     modulus_reg     <= cfg_data;
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[DCNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        steps_next        = steps_reg;
        have_digit_next   = have_digit_reg;
        result_valid_next = result_valid_reg && result_stall;
        mul_ctl           = '0;
        div_ctl           = '0;
        dig_ctl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (seed_take)
                begin
                    steps_next      = steps_sat;
                    have_digit_next = 1'b0;
                    cnt_next        = '0;
                    dig_ctl.clear   = 1'b1;
                    state_next      = (steps_sat == '0) ? ST_FINISH : ST_MUL;
                end
            end
            ST_MUL:
            begin
                mul_ctl.load  = (cnt_reg == '0);
                mul_ctl.run   = (cnt_reg != '0);
                dig_ctl.load  = (cnt_reg == '0);
                dig_ctl.run   = (cnt_reg != '0);
                dig_ctl.accum = cnt_last && have_digit_reg;
                cnt_next      = cnt_reg + BIT_CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_ctl.load = (cnt_reg == '0);
                div_ctl.run  = (cnt_reg != '0);
                cnt_next     = cnt_reg + BIT_CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next        = '0;
                    have_digit_next = 1'b1;
                    steps_next      = steps_reg - DCNT_W'(1);
                    state_next      = (steps_reg == DCNT_W'(1)) ? ST_DIG : ST_MUL;
                end
            end
            ST_DIG:
            begin
                dig_ctl.load  = (cnt_reg == '0);
                dig_ctl.run   = (cnt_reg != '0);
                dig_ctl.accum = cnt_last;
                cnt_next      = cnt_reg + BIT_CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            steps_reg        <= '0;
            have_digit_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            steps_reg        <= steps_next;
            have_digit_reg   <= have_digit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // seed and result payload
    always_ff @(posedge clk)
    begin
        if (seed_take)
        begin
            seed_reg <= seed_value;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            result_reg <= acc;
        end
    end

    assign result_valid = result_valid_reg;
    assign digit_number = result_reg;

    // serial multiply-add
    ldg_mul u_mul (
        .clk        (clk),
        .ctl        (mul_ctl),
        .multiplier (multiplier_reg),
        .increment  (increment_reg),
        .x_in       (state_x),
        .product    (product)
    );

    // serial remainder
    ldg_div u_div (
        .clk       (clk),
        .ctl       (div_ctl),
        .dividend  (product),
        .modulus   (modulus_reg),
        .remainder (remainder)
    );

    // serial mod-10 and decimal accumulator
    ldg_dig u_dig (
        .clk  (clk),
        .ctl  (dig_ctl),
        .x_in (state_x),
        .acc  (acc)
    );

    // a new result beat only comes out of the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish state");

    // the step count never exceeds the saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= DIGIT_MAX)
        else $error("step count above limit");

    // serial phases only run with steps left and a bounded bit counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV)
            |-> (steps_reg != '0) && (cnt_reg <= BIT_CNT_W'(WORD_W)))
        else $error("serial phase with no steps left");

    // a pending result beat is held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(digit_number)))
        else $error("stalled result changed");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LCG decimal digit generator. A scripted
// opening pass covers register extremes, the zero modulus, zero and
// saturating digit counts and writes to unused register indexes. Random
// register settings and seeds follow. Every result beat is compared with
// a typed value or with a bit-accurate model of the generator kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import ldg_pkg::*;

    // unused register indexes, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] NINES_19 = 64'd9999999999999999999;
    localparam logic [WORD_W-1:0] LOW5     = 64'h1F;

    localparam int GAP_MAX       = 17;
    localparam int LONG_HOLD     = 6000;
    localparam int HOLD_AT       = 60;
    localparam int QUIET_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 2600;
    localparam int PHASES        = 12;
    localparam int SEEDS_PER_PHS = 18;

    logic                 clk;
    logic                 rst_n;
    logic                 seed_valid;
    logic                 seed_stall;
    logic [WORD_W-1:0]    seed_value;
    logic                 result_valid;
    logic                 result_stall;
    logic [WORD_W-1:0]    digit_number;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    // bench copy of the configuration
    logic [WORD_W-1:0] lcg_mult;
    logic [WORD_W-1:0] lcg_inc;
    logic [WORD_W-1:0] lcg_mod;
    logic [DCNT_W-1:0] lcg_count;

    logic [WORD_W-1:0] pending_digits[$];
    logic [WORD_W-1:0] want_digits;
    int                errors;
    int                results_seen;
    int                quiet_cycles;
    bit                steady;
    bit                hold_done;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
        bit                   typed;
        logic [WORD_W-1:0]    want;
    } stim_row_t;

    stim_row_t script[$];

    lcg_decimal_digit_generator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_valid   (seed_valid),
        .seed_stall   (seed_stall),
        .seed_value   (seed_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .digit_number (digit_number),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock, period 12
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // digits collected from the generator run for one seed
    function automatic logic [WORD_W-1:0] digits_from_seed(logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] acc;
        int                steps;
        int                i;
        x     = seed;
        acc   = '0;
        steps = (lcg_count > DIGIT_MAX) ? int'(DIGIT_MAX) : int'(lcg_count);
        for (i = 0; i < steps; i++)
        begin
            sum = lcg_mult * x + lcg_inc;
            x   = (lcg_mod == '0) ? sum : sum % lcg_mod;
            acc = acc * WORD_W'(DEC_BASE) + x % WORD_W'(DEC_BASE);
        end
        return acc;
    endfunction

    // register write as seen by the model
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        case (idx)
            REG_MULTIPLIER:  lcg_mult  = data;
            REG_INCREMENT:   lcg_inc   = data;
            REG_MODULUS:     lcg_mod   = data;
            REG_DIGIT_COUNT: lcg_count = data[DCNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(GAP_MAX, 0);
    endfunction

    // register values biased towards the corners
    function automatic logic [WORD_W-1:0] pick_coeff();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return ALL_ONES;
            2: return WORD_W'($urandom_range(1000, 1));
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_modulus();
        case ($urandom_range(6, 0))
            0: return '0;
            1: return ALL_ONES;
            2: return WORD_W'($urandom_range(100, 1));
            3: return WORD_W'(1) << $urandom_range(63, 0);
            4: return WORD_W'(DEC_BASE);
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return ALL_ONES;
            2: return WORD_W'(1) << $urandom_range(63, 0);
            default: return rand_word();
        endcase
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        stim_row_t r;
        r.is_reg = 1'b1;
        r.index  = idx;
        r.data   = data;
        r.typed  = 1'b0;
        r.want   = '0;
        script.push_back(r);
    endfunction

    function automatic void add_seed(logic [WORD_W-1:0] seed, bit typed,
                                     logic [WORD_W-1:0] want);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.index  = '0;
        r.data   = seed;
        r.typed  = typed;
        r.want   = want;
        script.push_back(r);
    endfunction

    // one seed beat after a random gap, or none in steady phases, expectation logged on acceptance
    task automatic send_seed(logic [WORD_W-1:0] seed, bit typed, logic [WORD_W-1:0] want);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk) seed_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        seed_valid <= 1'b1;
        seed_value <= seed;
        do @(posedge clk); while (seed_stall !== 1'b0);
        pending_digits.push_back(typed ? want : digits_from_seed(seed));
    endtask

    // stop offering seeds and wait for every outstanding result
    task automatic drain();
        @(negedge clk) seed_valid <= 1'b0;
        wait (pending_digits.size() == 0);
    endtask

    // register write, only once the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_reg(idx, data);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // result side back-pressure, with one long hold-off
    initial
    begin
        int n;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                n = LONG_HOLD;
            end
            else
                n = draw_gap();
            repeat (n) @(negedge clk) result_stall <= 1'b1;
            @(negedge clk) result_stall <= 1'b0;
            do @(posedge clk); while (!(result_valid === 1'b1 && result_stall === 1'b0));
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            results_seen <= results_seen + 1;
            if (pending_digits.size() == 0)
            begin
                $error("digit_number: no result expected, got %0d", digit_number);
                errors <= errors + 1;
            end
            else
            begin
                want_digits = pending_digits.pop_front();
                if (digit_number !== want_digits)
                begin
                    $error("digit_number: expected %0d, actual %0d", want_digits,
                           digit_number);
                    errors <= errors + 1;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((seed_valid && seed_stall === 1'b0) ||
            (result_valid === 1'b1 && result_stall === 1'b0) ||
            (cfg_valid && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t            row;
        int                   ph;
        int                   k;
        logic [DCNT_W-1:0]    cnt;
        logic [CFG_IDX_W-1:0] spare;

        rst_n        = 1'b0;
        seed_valid   = 1'b0;
        seed_value   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        results_seen = 0;
        quiet_cycles = 0;
        steady       = 1'b0;
        hold_done    = 1'b0;
        lcg_mult     = MULTIPLIER_RST;
        lcg_inc      = INCREMENT_RST;
        lcg_mod      = MODULUS_RST;
        lcg_count    = DIGIT_COUNT_RST;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed script: reset values, corners and special cases
        add_seed('0, 1'b0, '0);
        add_seed(ALL_ONES, 1'b0, '0);
        add_reg(REG_DIGIT_COUNT, 64'd0);
        add_seed(64'h1234_5678_9ABC_DEF0, 1'b1, '0);
        // zero multiplier and zero modulus: every state is the increment
        add_reg(REG_MULTIPLIER, '0);
        add_reg(REG_INCREMENT, 64'd7);
        add_reg(REG_MODULUS, '0);
        add_reg(REG_DIGIT_COUNT, 64'd3);
        add_seed(ALL_ONES, 1'b1, 64'd777);
        add_reg(REG_INCREMENT, 64'd9);
        add_reg(REG_DIGIT_COUNT, 64'd19);
        add_seed('0, 1'b1, NINES_19);
        // counts above nineteen saturate
        add_reg(REG_DIGIT_COUNT, 64'd31);
        add_seed(64'd5, 1'b1, NINES_19);
        add_reg(REG_DIGIT_COUNT, 64'd20);
        add_seed(ALL_ONES, 1'b1, NINES_19);
        // unused indexes leave the registers alone
        add_reg(REG_SPARE_LO, '0);
        add_reg(REG_SPARE_HI, ALL_ONES);
        add_seed(64'd3, 1'b1, NINES_19);
        // modulus of one forces every state to zero
        add_reg(REG_MULTIPLIER, ALL_ONES);
        add_reg(REG_INCREMENT, ALL_ONES);
        add_reg(REG_MODULUS, 64'd1);
        add_seed(ALL_ONES, 1'b1, '0);
        add_reg(REG_MODULUS, ALL_ONES);
        add_seed('0, 1'b0, '0);
        add_seed(ALL_ONES, 1'b0, '0);
        add_seed(64'h8000_0000_0000_0000, 1'b0, '0);
        // upper data bits above the count field are dropped
        add_reg(REG_MULTIPLIER, 64'd3);
        add_reg(REG_INCREMENT, 64'd1);
        add_reg(REG_MODULUS, 64'd10);
        add_reg(REG_DIGIT_COUNT, 64'hFFFF_FFFF_FFFF_FFE1);
        add_seed(64'd2, 1'b1, 64'd7);
        add_reg(REG_MODULUS, '0);
        add_reg(REG_MULTIPLIER, 64'h5851_F42D_4C95_7F2D);
        add_reg(REG_INCREMENT, 64'h1405_7B7E_F767_814F);
        add_reg(REG_DIGIT_COUNT, 64'd19);
        add_seed('0, 1'b0, '0);
        add_seed(ALL_ONES, 1'b0, '0);

        foreach (script[i])
        begin
            row = script[i];
            if (row.is_reg)
                write_reg(row.index, row.data);
            else
                send_seed(row.data, row.typed, row.want);
        end

        // random phases, each with its own register setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            steady = (ph == 3 || ph == 8);
            write_reg(REG_MULTIPLIER, pick_coeff());
            write_reg(REG_INCREMENT, pick_coeff());
            write_reg(REG_MODULUS, pick_modulus());
            if (ph == 2)
                cnt = '0;
            else if (ph == 5 || ph == 10)
                cnt = DIGIT_MAX;
            else if (ph == 7)
                cnt = DCNT_W'($urandom_range(31, 20));
            else
                cnt = DCNT_W'($urandom_range(8, 1));
            write_reg(REG_DIGIT_COUNT, (rand_word() & ~LOW5) | WORD_W'(cnt));
            if ($urandom_range(3, 0) == 0)
            begin
                spare = CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO));
                write_reg(spare, rand_word());
            end
            for (k = 0; k < SEEDS_PER_PHS; k++)
                send_seed(pick_seed(), 1'b0, '0);
        end
        steady = 1'b0;

        // wind down and catch any stray result
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> files.f
design/ldg_pkg.sv
design/ldg_mul.sv
design/ldg_div.sv
design/ldg_dig.sv
design/lcg_decimal_digit_generator.sv
dv/tb_top.sv
